// File: design/tpc_pkg.sv
package tpc_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int DATA_BITS = 16;
  localparam int DUTY_FULL = 100;
  localparam int DUTY_SHIFT = 24;
  localparam int DUTY_FACTOR_BITS = DUTY_SHIFT + 1;
  localparam int DUTY_BITS = 7;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_EVENT = 3'd2;
  localparam logic [2:0] REG_COUNTER = 3'd3;
  localparam logic [2:0] REG_PRESCALER = 3'd4;
  localparam logic [2:0] REG_RELOAD = 3'd5;
  localparam logic [2:0] REG_COMPARE = 3'd6;
  localparam logic [2:0] REG_DUTY = 3'd7;

  // Control register bit positions.
  localparam int CTRL_COUNT_EN = 0;
  localparam int CTRL_RELOAD_PRE = 1;
  localparam int CTRL_COMPARE_PRE = 2;
  localparam int CTRL_OUTPUT_EN = 3;

  typedef struct packed {
    logic [1:0]           operation;
    logic [2:0]           reg_index;
    logic [DATA_BITS-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] read_data;
    logic                 pwm_level;
    logic                 update_flag;
    logic                 update_pulse;
  } result_t;

  typedef logic [DUTY_FACTOR_BITS-1:0] duty_table_t [0:(1 << DUTY_BITS)-1];

  // Scaled reciprocal factors: ceil(d * 2^DUTY_SHIFT / 100) for every duty code.
  function automatic duty_table_t build_duty_table();
    duty_table_t tbl;
    longint      num;
    for (int i = 0; i < (1 << DUTY_BITS); i++) begin
      num = (longint'(i) << DUTY_SHIFT) + longint'(DUTY_FULL - 1);
      tbl[i] = DUTY_FACTOR_BITS'(num / DUTY_FULL);
    end
    return tbl;
  endfunction

  localparam duty_table_t DUTY_TABLE = build_duty_table();

endpackage

// File: design/tpc_stream_if.sv
interface tpc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/timer_pwm_channel.sv
// Latency: a result is valid in the cycle after its transaction is accepted,
// or later while the receiver holds the output slot.
// Throughput: one transaction per clock cycle unless the skid slot is full,
// every operation alike. State update and duty multiply are combinational.
// A two-slot output buffer lets input keep flowing while one result waits.
// Reset (synchronous, active high) clears the control, flag, counters and
// compare values, sets both reload values to all ones and empties the buffer.
module timer_pwm_channel #(
  parameter int COUNT_BITS = tpc_pkg::COUNT_BITS_DEFAULT
) (
  input logic   clk,
  input logic   rst,
  tpc_stream_if.sink   in_ch,
  tpc_stream_if.source out_ch
);
  import tpc_pkg::*;

  // The counter-wide registers are held in at most sixteen bits of storage.
  localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  item_t   item;
  result_t result;
  logic    accept;

  // Timer state.
  logic [3:0]           control_bits, control_bits_next;
  logic                 flag_reg, flag_reg_next;
  logic [DATA_BITS-1:0] prescale_count, prescale_count_next;
  logic [CW-1:0]        count_value, count_value_next;
  logic [DATA_BITS-1:0] prescale_pending, prescale_pending_next;
  logic [DATA_BITS-1:0] prescale_active, prescale_active_next;
  logic [CW-1:0]        reload_pending, reload_pending_next;
  logic [CW-1:0]        reload_active, reload_active_next;
  logic [CW-1:0]        compare_pending, compare_pending_next;
  logic [CW-1:0]        compare_active, compare_active_next;

  logic                 upd_event;
  logic [DATA_BITS-1:0] rd_value;
  logic [CW-1:0]        duty_compare;

  // Output buffer: the main slot drives the port, the skid slot catches a
  // result produced while the main slot is stalled.
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    pop;

  assign item = in_ch.data;
  assign in_ch.ready = !skid_valid;
  assign accept = in_ch.valid && in_ch.ready;
  assign pop = out_valid && out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  tpc_duty #(
    .COUNT_BITS(COUNT_BITS)
  ) u_duty (
    .value   (item.write_data),
    .reload  (reload_pending),
    .compare (duty_compare)
  );

  // Next state for the transaction on the input side. The registers only
  // take these values when the transaction is accepted.
  always_comb begin
    control_bits_next = control_bits;
    flag_reg_next = flag_reg;
    prescale_count_next = prescale_count;
    count_value_next = count_value;
    prescale_pending_next = prescale_pending;
    prescale_active_next = prescale_active;
    reload_pending_next = reload_pending;
    reload_active_next = reload_active;
    compare_pending_next = compare_pending;
    compare_active_next = compare_active;
    upd_event = 1'b0;
    rd_value = '0;

    case (item.operation)
      OP_TICK: begin
        if (control_bits[CTRL_COUNT_EN]) begin
          if (prescale_count >= prescale_active) begin
            prescale_count_next = '0;
            // A counter at or above the reload value wraps, which also
            // covers a counter written above the reload.
            if (count_value >= reload_active) begin
              upd_event = 1'b1;
            end else begin
              count_value_next = count_value + CW'(1);
            end
          end else begin
            prescale_count_next = prescale_count + DATA_BITS'(1);
          end
        end
      end
      OP_WRITE: begin
        case (item.reg_index)
          REG_CTRL: control_bits_next = item.write_data[3:0];
          REG_STATUS: begin
            if (!item.write_data[0]) begin
              flag_reg_next = 1'b0;
            end
          end
          REG_EVENT: upd_event = item.write_data[0];
          REG_COUNTER: count_value_next = item.write_data[CW-1:0];
          REG_PRESCALER: prescale_pending_next = item.write_data;
          REG_RELOAD: begin
            reload_pending_next = item.write_data[CW-1:0];
            if (!control_bits[CTRL_RELOAD_PRE]) begin
              reload_active_next = item.write_data[CW-1:0];
            end
          end
          REG_COMPARE: begin
            compare_pending_next = item.write_data[CW-1:0];
            if (!control_bits[CTRL_COMPARE_PRE]) begin
              compare_active_next = item.write_data[CW-1:0];
            end
          end
          REG_DUTY: begin
            compare_pending_next = duty_compare;
            if (!control_bits[CTRL_COMPARE_PRE]) begin
              compare_active_next = duty_compare;
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        // Reads of the preloaded registers return the pending values.
        case (item.reg_index)
          REG_CTRL: rd_value = DATA_BITS'(control_bits);
          REG_STATUS: rd_value = DATA_BITS'(flag_reg);
          REG_COUNTER: rd_value = DATA_BITS'(count_value);
          REG_PRESCALER: rd_value = prescale_pending;
          REG_RELOAD: rd_value = DATA_BITS'(reload_pending);
          REG_COMPARE: rd_value = DATA_BITS'(compare_pending);
          default: rd_value = '0;
        endcase
      end
      default: ;
    endcase

    // An update event restarts both counters and loads the shadow registers
    // from the values pending before this transaction.
    if (upd_event) begin
      count_value_next = '0;
      prescale_count_next = '0;
      prescale_active_next = prescale_pending;
      reload_active_next = reload_pending;
      compare_active_next = compare_pending;
      flag_reg_next = 1'b1;
    end

    // The reported levels are those after the transaction.
    result.read_data = rd_value;
    result.pwm_level = control_bits_next[CTRL_OUTPUT_EN] &&
                       (count_value_next < compare_active_next);
    result.update_flag = flag_reg_next;
    result.update_pulse = upd_event;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits <= '0;
      flag_reg <= 1'b0;
      prescale_count <= '0;
      count_value <= '0;
      prescale_pending <= '0;
      prescale_active <= '0;
      reload_pending <= '1;
      reload_active <= '1;
      compare_pending <= '0;
      compare_active <= '0;
    end else if (accept) begin
      control_bits <= control_bits_next;
      flag_reg <= flag_reg_next;
      prescale_count <= prescale_count_next;
      count_value <= count_value_next;
      prescale_pending <= prescale_pending_next;
      prescale_active <= prescale_active_next;
      reload_pending <= reload_pending_next;
      reload_active <= reload_active_next;
      compare_pending <= compare_pending_next;
      compare_active <= compare_active_next;
    end
  end

  // Output buffer. While the skid slot is full no transaction is accepted,
  // so at most one new result and one waiting result ever compete.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_data <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // The skid slot only fills behind a waiting result.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a result while the output slot is empty");

  // An update event leaves the flag set and both counters cleared.
  a_update_effect : assert property (@(posedge clk) disable iff (rst)
    accept && upd_event |=> flag_reg && (count_value == '0) && (prescale_count == '0))
    else $error("update event did not set the flag and clear the counters");

  // With counting disabled a tick leaves both counters alone.
  a_stopped_tick : assert property (@(posedge clk) disable iff (rst)
    accept && (item.operation == OP_TICK) && !control_bits[CTRL_COUNT_EN]
    |=> $stable(count_value) && $stable(prescale_count))
    else $error("counter moved on a tick while stopped");

  // A transaction accepted while the output slot is empty lands in that slot.
  a_result_stored : assert property (@(posedge clk) disable iff (rst)
    accept && !out_valid |=> out_valid && !skid_valid)
    else $error("accepted transaction did not reach the output slot");
endmodule

// File: design/tpc_duty.sv
module tpc_duty #(
  parameter int COUNT_BITS = tpc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic [tpc_pkg::DATA_BITS-1:0]                  value,
  input  logic [((COUNT_BITS < 16) ? COUNT_BITS : 16)-1:0] reload,
  output logic [((COUNT_BITS < 16) ? COUNT_BITS : 16)-1:0] compare
);
  import tpc_pkg::*;

  localparam int CW = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int PROD_BITS = CW + 1 + DUTY_FACTOR_BITS;
  localparam int QUOT_BITS = PROD_BITS - DUTY_SHIFT;

  logic [DUTY_BITS-1:0]        duty;
  logic [DUTY_FACTOR_BITS-1:0] factor;
  logic [CW:0]                 span;
  logic [PROD_BITS-1:0]        prod;
  logic [QUOT_BITS-1:0]        quot;

  // The scaled reciprocal turns the divide by one hundred into one multiply and a shift.
  assign duty = (value > DATA_BITS'(DUTY_FULL)) ? DUTY_BITS'(DUTY_FULL) : value[DUTY_BITS-1:0];
  assign factor = DUTY_TABLE[duty];
  assign span = {1'b0, reload} + (CW + 1)'(1);
  assign prod = PROD_BITS'(span) * PROD_BITS'(factor);
  assign quot = prod[PROD_BITS-1:DUTY_SHIFT];
  assign compare = (quot > QUOT_BITS'({CW{1'b1}})) ? {CW{1'b1}} : quot[CW-1:0];
endmodule
